@@ rtl/core/u2w_pkg.sv @@
// Shared types and constants for the UTF-8 to wide-character decoder.
package u2w_pkg;

   // Field widths of the byte stream and of the decoded units.
   localparam int ByteWidth = 8;
   localparam int UnitWidth = 21;
   localparam int LowWidth  = 10;

   // Configuration port geometry.
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   // Register index of the UTF-16 mode bit (taken from paddr[2]).
   localparam logic RegUtf16Mode = 1'b0;

   // Character constants.
   localparam logic [UnitWidth-1:0] Qmark        = 21'd63;
   localparam logic [UnitWidth-1:0] ByteOrderMark = 21'h00FEFF;
   localparam logic [UnitWidth-1:0] SurrHighBase = 21'h00D7C0;
   localparam logic [UnitWidth-1:0] SurrLowBase  = 21'h00DC00;

   // One classified character or status event passed from front to back.
   typedef struct packed {
      logic [UnitWidth-1:0] unit0;       // first (or only) unit
      logic [LowWidth-1:0]  low_bits;    // low ten bits for the low surrogate
      logic                 two_units;   // a surrogate pair follows
      logic                 has_char;
      logic                 is_error;
      logic                 string_end;
      logic                 string_ok;
   } job_type;

endpackage

@@ rtl/core/u2w_if.sv @@
// Valid/ready channel interfaces for the byte stream and the decoded results.
interface u2w_req_if;
   logic                           valid;
   logic                           ready;
   logic [u2w_pkg::ByteWidth-1:0]  byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface u2w_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [u2w_pkg::UnitWidth-1:0]  code_unit;
   logic                           has_char;
   logic                           is_error;
   logic                           string_end;
   logic                           string_ok;
   logic                           last;

   modport source (output valid, output code_unit, output has_char, output is_error,
                   output string_end, output string_ok, output last, input ready);
   modport sink   (input valid, input code_unit, input has_char, input is_error,
                   input string_end, input string_ok, input last, output ready);
endinterface

@@ rtl/core/u2w_front.sv @@
// Front end: accepts UTF-8 bytes, tracks sequence state and classifies results.
module u2w_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 utf16_mode,
   u2w_req_if.sink              req,
   output logic                 push_valid,
   input  logic                 push_ready,
   output u2w_pkg::job_type     push_job
);

   logic [1:0]                      bytes_pending_ff, bytes_pending_in;
   logic [u2w_pkg::UnitWidth-1:0]   partial_value_ff, partial_value_in;
   logic                            at_string_start_ff, at_string_start_in;
   logic                            error_seen_ff, error_seen_in;

   logic                            accept;
   logic [u2w_pkg::ByteWidth-1:0]   b;
   logic [u2w_pkg::UnitWidth-1:0]   cont_value;
   logic [1:0]                      pending_dec;
   logic                            char_done;
   logic [u2w_pkg::UnitWidth-1:0]   char_value;
   u2w_pkg::job_type                char_job;

   // A byte may always cause a result, so take one only when the queue has room.
   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign b         = req.byte_in;

   assign cont_value  = {partial_value_ff[u2w_pkg::UnitWidth-7:0], b[5:0]};
   assign pending_dec = bytes_pending_ff - 2'd1;

   // Shape a finished character, splitting it into surrogates when required.
   always_comb begin
      char_job            = '0;
      char_job.has_char   = 1'b1;
      char_job.low_bits   = char_value[u2w_pkg::LowWidth-1:0];
      char_job.two_units  = utf16_mode && (char_value[u2w_pkg::UnitWidth-1:16] != '0);
      if (char_job.two_units) begin
         char_job.unit0 = u2w_pkg::SurrHighBase +
                          {10'd0, char_value[u2w_pkg::UnitWidth-1:u2w_pkg::LowWidth]};
      end else begin
         char_job.unit0 = char_value;
      end
   end

   // Sequence state machine and result selection.
   always_comb begin
      bytes_pending_in   = bytes_pending_ff;
      partial_value_in   = partial_value_ff;
      at_string_start_in = at_string_start_ff;
      error_seen_in      = error_seen_ff;
      char_done          = 1'b0;
      char_value         = cont_value;
      push_valid         = 1'b0;
      push_job           = char_job;

      if (accept) begin
         if (b == '0) begin
            // Terminating zero byte: report truncation or a clean end.
            push_valid          = 1'b1;
            push_job            = '0;
            push_job.string_end = 1'b1;
            if (bytes_pending_ff != 2'd0) begin
               push_job.unit0    = u2w_pkg::Qmark;
               push_job.has_char = 1'b1;
               push_job.is_error = 1'b1;
            end else begin
               push_job.string_ok = !error_seen_ff;
            end
            bytes_pending_in   = 2'd0;
            partial_value_in   = '0;
            at_string_start_in = 1'b1;
            error_seen_in      = 1'b0;
         end else if (bytes_pending_ff != 2'd0) begin
            // Continuation byte: gather six bits.
            partial_value_in = cont_value;
            bytes_pending_in = pending_dec;
            char_done        = (pending_dec == 2'd0);
            char_value       = cont_value;
         end else if (b[7] == 1'b0) begin
            char_done  = 1'b1;
            char_value = {13'd0, b};
         end else if (b[7:5] == 3'b110) begin
            partial_value_in = {16'd0, b[4:0]};
            bytes_pending_in = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            partial_value_in = {17'd0, b[3:0]};
            bytes_pending_in = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            partial_value_in = {18'd0, b[2:0]};
            bytes_pending_in = 2'd3;
         end else begin
            // Bad lead byte.
            error_seen_in      = 1'b1;
            at_string_start_in = 1'b0;
            push_valid         = 1'b1;
            push_job           = '0;
            push_job.unit0     = u2w_pkg::Qmark;
            push_job.has_char  = 1'b1;
            push_job.is_error  = 1'b1;
         end

         // A byte order mark opening the string is dropped.
         if (char_done) begin
            at_string_start_in = 1'b0;
            push_valid = !(at_string_start_ff && (char_value == u2w_pkg::ByteOrderMark));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff   <= 2'd0;
         partial_value_ff   <= '0;
         at_string_start_ff <= 1'b1;
         error_seen_ff      <= 1'b0;
      end else begin
         bytes_pending_ff   <= bytes_pending_in;
         partial_value_ff   <= partial_value_in;
         at_string_start_ff <= at_string_start_in;
         error_seen_ff      <= error_seen_in;
      end
   end

endmodule

@@ rtl/core/u2w_queue.sv @@
// Short register queue of classified results between front and back.
module u2w_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  u2w_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output u2w_pkg::job_type  pop_job
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   u2w_pkg::job_type        slots_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]     count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != CntWidth'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/core/u2w_back.sv @@
// Back end: expands queued results into beats, two for a surrogate pair.
module u2w_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  u2w_pkg::job_type  pop_job,
   u2w_rsp_if.source         rsp
);

   logic                           valid_ff, valid_in;
   logic                           second_ff, second_in;
   logic [u2w_pkg::LowWidth-1:0]   low_bits_ff, low_bits_in;
   logic [u2w_pkg::UnitWidth-1:0]  code_unit_ff, code_unit_in;
   logic                           has_char_ff, has_char_in;
   logic                           is_error_ff, is_error_in;
   logic                           string_end_ff, string_end_in;
   logic                           string_ok_ff, string_ok_in;
   logic                           last_ff, last_in;
   logic                           load;

   // The output register may be refilled when empty or being taken.
   assign load      = !valid_ff || rsp.ready;
   assign pop_ready = load && !second_ff;

   always_comb begin
      valid_in      = valid_ff;
      second_in     = second_ff;
      low_bits_in   = low_bits_ff;
      code_unit_in  = code_unit_ff;
      has_char_in   = has_char_ff;
      is_error_in   = is_error_ff;
      string_end_in = string_end_ff;
      string_ok_in  = string_ok_ff;
      last_in       = last_ff;
      if (load) begin
         if (second_ff) begin
            // Low surrogate of a pair.
            valid_in      = 1'b1;
            second_in     = 1'b0;
            code_unit_in  = u2w_pkg::SurrLowBase | {11'd0, low_bits_ff};
            has_char_in   = 1'b1;
            is_error_in   = 1'b0;
            string_end_in = 1'b0;
            string_ok_in  = 1'b0;
            last_in       = 1'b1;
         end else if (pop_valid) begin
            valid_in      = 1'b1;
            second_in     = pop_job.two_units;
            low_bits_in   = pop_job.low_bits;
            code_unit_in  = pop_job.unit0;
            has_char_in   = pop_job.has_char;
            is_error_in   = pop_job.is_error;
            string_end_in = pop_job.string_end;
            string_ok_in  = pop_job.string_ok;
            last_in       = !pop_job.two_units;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      low_bits_ff   <= low_bits_in;
      code_unit_ff  <= code_unit_in;
      has_char_ff   <= has_char_in;
      is_error_ff   <= is_error_in;
      string_end_ff <= string_end_in;
      string_ok_ff  <= string_ok_in;
      last_ff       <= last_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.code_unit  = code_unit_ff;
   assign rsp.has_char   = has_char_ff;
   assign rsp.is_error   = is_error_ff;
   assign rsp.string_end = string_end_ff;
   assign rsp.string_ok  = string_ok_ff;
   assign rsp.last       = last_ff;

endmodule

@@ rtl/core/utf8_to_wide_decoder.sv @@
// Top level of the UTF-8 to wide-character decoder.
// The decoder takes one UTF-8 byte per cycle on req_bus while the queue between front and
// back (QUEUE_DEPTH entries) has room; an accepted byte's result goes into the queue and
// then into the back end's output register, which drives rsp_bus. A continuation byte that
// does not finish a character gives no beat. In UTF-16 mode a character at or above U+10000
// leaves as two beats (high surrogate, then low surrogate with last set) one after the
// other; its non-finishing bytes absorb the extra beat, so the sustained input rate stays
// one byte per cycle while rsp_bus is not stalled. A stalled result port backs up into the
// queue and then holds off req_bus. The zero byte ends a string and gives one end beat,
// with string_ok set only if the string had no error. utf16_mode sits at byte address 0 of
// the APB port and should be written only while no bytes are in flight.
module utf8_to_wide_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   u2w_req_if.sink                              req_bus,
   u2w_rsp_if.source                            rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [u2w_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [u2w_pkg::CsrDataWidth-1:0]     pwdata,
   output logic [u2w_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                 pready
);

   logic              utf16_mode_ff, utf16_mode_in;
   logic              csr_write;
   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   u2w_pkg::job_type  push_job, pop_job;

   // Configuration register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      utf16_mode_in = utf16_mode_ff;
      if (csr_write && (paddr[2] == u2w_pkg::RegUtf16Mode)) begin
         utf16_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         utf16_mode_ff <= 1'b0;
      end else begin
         utf16_mode_ff <= utf16_mode_in;
      end
   end

   assign prdata = (paddr[2] == u2w_pkg::RegUtf16Mode) ?
                   {{(u2w_pkg::CsrDataWidth-1){1'b0}}, utf16_mode_ff} : '0;

   u2w_front u_front (
      .clock      (clock),
      .reset      (reset),
      .utf16_mode (utf16_mode_ff),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   u2w_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   u2w_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp       (rsp_bus)
   );

   // The front end never offers a result the queue cannot take.
   assert property (@(posedge clock) disable iff (reset) push_valid |-> push_ready)
      else $error("front pushed a result into a full queue");

   // The first unit of a pair is followed at once by its low surrogate.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=>
         rsp_bus.valid && rsp_bus.has_char && !rsp_bus.is_error && !rsp_bus.string_end)
      else $error("surrogate pair broken");

   // An end-of-string beat is always the final beat of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.string_end |-> rsp_bus.last && !(rsp_bus.string_ok && rsp_bus.is_error))
      else $error("malformed end-of-string beat");

   // Error beats carry the replacement character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_error |-> rsp_bus.has_char && (rsp_bus.code_unit == u2w_pkg::Qmark))
      else $error("error beat without replacement character");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the UTF-8 to wide-character decoder.
`timescale 1ns / 1ps

// One result beat as it leaves the decoder.
typedef struct packed {
   logic [u2w_pkg::UnitWidth-1:0] code_unit;
   logic                          has_char;
   logic                          is_error;
   logic                          string_end;
   logic                          string_ok;
   logic                          last;
} wide_beat_type;

// Tracks the decoder state, predicts the beats of each accepted byte and checks them.
class decode_scoreboard;
   bit                          utf16_mode;
   bit [1:0]                    cont_left;
   bit [u2w_pkg::UnitWidth-1:0] gathered;
   bit                          fresh_string;
   bit                          string_bad;
   wide_beat_type               units_due[$];
   int unsigned                 mismatches;
   int unsigned                 beats_checked;
   int unsigned                 pairs_seen;

   function new();
      utf16_mode = 1'b0;
      mismatches = 0;
      beats_checked = 0;
      pairs_seen = 0;
      restart();
   endfunction

   function void restart();
      cont_left = 2'd0;
      gathered = '0;
      fresh_string = 1'b1;
      string_bad = 1'b0;
   endfunction

   function void set_mode(bit mode);
      utf16_mode = mode;
   endfunction

   function int outstanding();
      return units_due.size();
   endfunction

   function void push_beat(bit [u2w_pkg::UnitWidth-1:0] unit, bit has, bit err, bit fin,
                           bit ok, bit lst);
      wide_beat_type beat;
      beat.code_unit = unit;
      beat.has_char = has;
      beat.is_error = err;
      beat.string_end = fin;
      beat.string_ok = ok;
      beat.last = lst;
      units_due.insert(units_due.size(), beat);
   endfunction

   // A finished character: a leading byte order mark is dropped, and in UTF-16 mode
   // anything at or above U+10000 leaves as a surrogate pair.
   function void finish_char(bit [u2w_pkg::UnitWidth-1:0] value);
      bit first;
      first = fresh_string;
      fresh_string = 1'b0;
      if (value == u2w_pkg::ByteOrderMark && first)
         return;
      if (utf16_mode && value >= 21'h10000) begin
         push_beat(u2w_pkg::SurrHighBase + (value >> 10), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
         push_beat(u2w_pkg::SurrLowBase | {11'd0, value[9:0]}, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
         pairs_seen++;
      end else begin
         push_beat(value, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      end
   endfunction

   // Works out the beats that one accepted byte causes.
   function void note_byte(bit [7:0] data);
      if (data == 8'd0) begin
         if (cont_left != 2'd0)
            push_beat(u2w_pkg::Qmark, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
         else
            push_beat('0, 1'b0, 1'b0, 1'b1, !string_bad, 1'b1);
         restart();
      end else if (cont_left != 2'd0) begin
         // Continuation bytes give their low six bits; the prefix is not checked.
         gathered = {gathered[14:0], data[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0)
            finish_char(gathered);
      end else if (!data[7]) begin
         finish_char({13'd0, data});
      end else if (data[7:5] == 3'b110) begin
         gathered = {16'd0, data[4:0]};
         cont_left = 2'd1;
      end else if (data[7:4] == 4'b1110) begin
         gathered = {17'd0, data[3:0]};
         cont_left = 2'd2;
      end else if (data[7:3] == 5'b11110) begin
         gathered = {18'd0, data[2:0]};
         cont_left = 2'd3;
      end else begin
         // A stray continuation byte or an invalid lead byte.
         string_bad = 1'b1;
         fresh_string = 1'b0;
         push_beat(u2w_pkg::Qmark, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
      end
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Compares one accepted beat with the oldest prediction.
   function void check_beat(wide_beat_type got);
      wide_beat_type want;
      if (units_due.size() == 0) begin
         $error("unexpected beat: code_unit 0x%0h, string_end %0b", got.code_unit,
                got.string_end);
         mismatches++;
         return;
      end
      want = units_due.pop_front();
      beats_checked++;
      compare_field("code_unit", want.code_unit, got.code_unit);
      compare_field("has_char", want.has_char, got.has_char);
      compare_field("is_error", want.is_error, got.is_error);
      compare_field("string_end", want.string_end, got.string_end);
      compare_field("string_ok", want.string_ok, got.string_ok);
      compare_field("last", want.last, got.last);
   endfunction
endclass

module testbench;

   localparam int UnitWidth    = u2w_pkg::UnitWidth;
   localparam int CsrAddrWidth = u2w_pkg::CsrAddrWidth;
   localparam int CsrDataWidth = u2w_pkg::CsrDataWidth;
   localparam int MaxWait     = 18;
   localparam int HoldCycles  = 150;
   localparam int SettleCycles = 10;
   localparam int CycleLimit  = 300000;
   localparam int PhaseBytes  = 92;

   logic                    clock;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   u2w_req_if req_bus ();
   u2w_rsp_if rsp_bus ();

   decode_scoreboard sb;
   bit [7:0]         plan[$];
   bit               idling;
   bit               hold_ask;
   int unsigned      bytes_sent;
   int unsigned      strings_sent;
   int unsigned      cycles;

   utf8_to_wide_decoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Safety net: the run is abandoned if it takes far longer than it should.
   initial begin
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Appends one byte to the planned string.
   function automatic void add_byte(bit [7:0] data);
      plan.insert(plan.size(), data);
   endfunction

   // Offers one byte, after a random gap while idling is set, and waits until it is taken.
   task automatic send_byte(bit [7:0] data);
      int gap;
      gap = idling ? $urandom_range(0, MaxWait) : 0;
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.byte_in = data;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_byte(data);
      bytes_sent++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic send_plan();
      foreach (plan[i])
         send_byte(plan[i]);
      strings_sent++;
   endtask

   // Waits until every predicted beat has arrived and the block has gone quiet.
   task automatic drain();
      while (sb.outstanding() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Writes the mode register, then reads it back.
   task automatic write_mode(bit mode);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {u2w_pkg::RegUtf16Mode, 2'b00};
      pwdata = {31'd0, mode};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_mode(mode);
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[0] !== mode) begin
         $error("utf16_mode readback mismatch: expected %0b, got %0b", mode, prdata[0]);
         sb.mismatches++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   function automatic bit [7:0] cont_byte(bit [5:0] bits);
      bit [7:0] data;
      data = {2'b10, bits};
      // Now and then the prefix is wrong, which the decoder must ignore.
      if ($urandom_range(0, 7) == 0)
         data[7:6] = 2'($urandom_range(0, 3));
      if (data == 8'd0)
         data = {2'b10, bits};
      return data;
   endfunction

   // Encodes a value with the given sequence length; short values give overlong forms.
   function automatic void plan_char(bit [UnitWidth-1:0] value, int len);
      case (len)
         1: add_byte({1'b0, value[6:0]});
         2: begin
            add_byte({3'b110, value[10:6]});
            add_byte(cont_byte(value[5:0]));
         end
         3: begin
            add_byte({4'b1110, value[15:12]});
            add_byte(cont_byte(value[11:6]));
            add_byte(cont_byte(value[5:0]));
         end
         default: begin
            add_byte({5'b11110, value[20:18]});
            add_byte(cont_byte(value[17:12]));
            add_byte(cont_byte(value[11:6]));
            add_byte(cont_byte(value[5:0]));
         end
      endcase
   endfunction

   function automatic bit [UnitWidth-1:0] pick_value(int len);
      case (len)
         1: return UnitWidth'($urandom_range(1, 127));
         2: return UnitWidth'($urandom_range(0, 12'h7FF));
         3: return UnitWidth'($urandom_range(0, 16'hFFFF));
         default: begin
            if ($urandom_range(0, 3) == 0)
               return UnitWidth'($urandom_range(0, 21'h1FFFFF));
            return UnitWidth'($urandom_range(21'h10000, 21'h10FFFF));
         end
      endcase
   endfunction

   function automatic bit [7:0] pick_bad_lead();
      if ($urandom_range(0, 1) == 0)
         return 8'($urandom_range(8'h80, 8'hBF));
      return 8'($urandom_range(8'hF8, 8'hFF));
   endfunction

   // Builds and sends one random string: mostly well formed, some truncated,
   // some with bad lead bytes, and some pure noise.
   task automatic send_random_string();
      int kind;
      int count;
      int len;
      plan.delete();
      kind = $urandom_range(0, 99);
      idling = ($urandom_range(0, 3) != 0);
      if (kind >= 90) begin
         count = $urandom_range(1, 12);
         repeat (count) add_byte(8'($urandom_range(1, 255)));
      end else begin
         if ($urandom_range(0, 6) == 0)
            plan_char(u2w_pkg::ByteOrderMark, $urandom_range(3, 4));
         count = $urandom_range(0, 8);
         repeat (count) begin
            if (kind >= 80 && $urandom_range(0, 3) == 0)
               add_byte(pick_bad_lead());
            len = $urandom_range(1, 4);
            plan_char(pick_value(len), len);
         end
         if (kind >= 70 && kind < 80) begin
            // The string stops in the middle of a sequence.
            len = $urandom_range(2, 4);
            plan_char(pick_value(len), len);
            repeat ($urandom_range(1, len - 1)) void'(plan.pop_back());
         end
      end
      add_byte(8'd0);
      send_plan();
   endtask

   // Result side: random stalls per beat, plus one long hold-off on request.
   initial begin
      int stall;
      bit got;
      wide_beat_type beat;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = idling ? $urandom_range(0, MaxWait) : 0;
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         got = 1'b0;
         while (!got) begin
            @(posedge clock);
            if (rsp_bus.valid) begin
               beat.code_unit = rsp_bus.code_unit;
               beat.has_char = rsp_bus.has_char;
               beat.is_error = rsp_bus.is_error;
               beat.string_end = rsp_bus.string_end;
               beat.string_ok = rsp_bus.string_ok;
               beat.last = rsp_bus.last;
               sb.check_beat(beat);
               got = 1'b1;
            end
            @(negedge clock);
            if (hold_ask) begin
               hold_ask = 1'b0;
               rsp_bus.ready = 1'b0;
               repeat (HoldCycles) @(negedge clock);
               rsp_bus.ready = 1'b1;
            end
         end
      end
   end

   // Main sequence: reset, directed strings in both modes, then random phases.
   initial begin
      int phase_start;
      sb = new();
      idling = 1'b1;
      hold_ask = 1'b0;
      bytes_sent = 0;
      strings_sent = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.byte_in = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Leading byte order mark, ASCII extremes, both kinds of bad lead byte,
      // and a two-byte maximum; the string ends marked bad.
      write_mode(1'b0);
      plan = '{8'hEF, 8'hBB, 8'hBF, 8'h7F, 8'h01, 8'hF8, 8'h80, 8'hDF, 8'hBF, 8'h00};
      send_plan();
      // A byte order mark after the first character is kept; the end is clean.
      plan = '{8'h41, 8'hEF, 8'hBB, 8'hBF, 8'h00};
      send_plan();
      // A string cut off inside a three-byte sequence.
      plan = '{8'hE2, 8'h82, 8'h00};
      send_plan();
      drain();

      // Surrogate pairs for the top of Unicode and for the largest 21-bit value.
      write_mode(1'b1);
      plan = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00};
      send_plan();
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         write_mode(phase % 2 == 0);
         phase_start = bytes_sent;
         if (phase == 2) begin
            // Hold the result side off while bytes keep coming, so the block
            // fills up and stalls its input.
            idling = 1'b0;
            hold_ask = 1'b1;
            plan.delete();
            repeat (40) add_byte(8'($urandom_range(8'h20, 8'h7E)));
            add_byte(8'd0);
            send_plan();
         end
         while (bytes_sent - phase_start < PhaseBytes)
            send_random_string();
         idling = 1'b1;
         drain();
      end

      $display("Sent %0d bytes in %0d strings over both modes; checked %0d beats,",
               bytes_sent, strings_sent, sb.beats_checked);
      $display("including %0d surrogate pairs and a %0d-cycle result hold-off.",
               sb.pairs_seen, HoldCycles);
      if (sb.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
